>>> rtl/core/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared opcode codes and the control word that travels with each queued
// transaction from the front end to the back end.
// ----------------------------------------------------------------------------
package bls_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } bls_op_t;

    // Control flags of one queued transaction.
    typedef struct packed {
        logic load;
        logic x_negative;
        logic y_negative;
        logic steep;
    } bls_ctrl_t;

    localparam int unsigned CTRL_BITS = $bits(bls_ctrl_t);

endpackage

>>> rtl/core/bls_front.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper front end
// Classifies an incoming transaction and, for a load, works out the
// directions, the major axis and the decision increments of the new line.
// ----------------------------------------------------------------------------
module bls_front
    import bls_pkg::*;
#(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned DEC_BITS   = COORD_BITS + 3
)
(
    input  logic                       opcode,
    input  logic [COORD_BITS-1:0]      x_start,
    input  logic [COORD_BITS-1:0]      y_start,
    input  logic [COORD_BITS-1:0]      x_finish,
    input  logic [COORD_BITS-1:0]      y_finish,
    output bls_ctrl_t                  ctrl,
    output logic signed [DEC_BITS-1:0] decision_init,
    output logic signed [DEC_BITS-1:0] inc_minor,
    output logic signed [DEC_BITS-1:0] inc_both
);

    localparam int unsigned PAD_BITS = DEC_BITS - COORD_BITS;

    logic                       x_neg;
    logic                       y_neg;
    logic                       is_steep;
    logic [COORD_BITS-1:0]      delta_x;
    logic [COORD_BITS-1:0]      delta_y;
    logic [COORD_BITS-1:0]      delta_major;
    logic [COORD_BITS-1:0]      delta_minor;
    logic signed [DEC_BITS-1:0] major_ext;
    logic signed [DEC_BITS-1:0] minor_ext;

    always_comb
    begin
        x_neg       = x_finish < x_start;
        y_neg       = y_finish < y_start;
        delta_x     = x_neg ? (x_start - x_finish) : (x_finish - x_start);
        delta_y     = y_neg ? (y_start - y_finish) : (y_finish - y_start);
        is_steep    = delta_y > delta_x;
        delta_major = is_steep ? delta_y : delta_x;
        delta_minor = is_steep ? delta_x : delta_y;

        major_ext = signed'({{PAD_BITS{1'b0}}, delta_major});
        minor_ext = signed'({{PAD_BITS{1'b0}}, delta_minor});

        // The decision term grows by twice the minor delta on every step and
        // loses twice the major delta whenever the minor axis moves.
        inc_minor     = minor_ext <<< 1;
        inc_both      = (minor_ext <<< 1) - (major_ext <<< 1);
        decision_init = (minor_ext <<< 1) - major_ext;

        ctrl.load       = (bls_op_t'(opcode) == OP_LOAD);
        ctrl.x_negative = x_neg;
        ctrl.y_negative = y_neg;
        ctrl.steep      = is_steep;
    end

endmodule

>>> rtl/core/bls_queue.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bls_queue
#(
    parameter int unsigned WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_write;
    logic             do_read;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        empty       = (count_reg == 2'd0);
        do_write    = wr_valid && !full;
        do_read     = rd_en && !empty;
        wr_ptr_next = do_write ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_read ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_write && !do_read)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 2'd1;
        end
        rd_data = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/bls_back.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper back end
// Holds the line state, executes queued loads and steps, and keeps the
// pixel output register.
// ----------------------------------------------------------------------------
module bls_back
    import bls_pkg::*;
#(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned DEC_BITS   = COORD_BITS + 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       entry_valid,
    input  bls_ctrl_t                  entry_ctrl,
    input  logic [COORD_BITS-1:0]      entry_start_x,
    input  logic [COORD_BITS-1:0]      entry_start_y,
    input  logic [COORD_BITS-1:0]      entry_end_x,
    input  logic [COORD_BITS-1:0]      entry_end_y,
    input  logic signed [DEC_BITS-1:0] entry_decision,
    input  logic signed [DEC_BITS-1:0] entry_inc_minor,
    input  logic signed [DEC_BITS-1:0] entry_inc_both,
    output logic                       entry_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       last_pixel
);

    bls_ctrl_t                  ctrl_reg;
    logic                       active_reg;
    logic                       active_next;
    logic [COORD_BITS-1:0]      cur_x_reg;
    logic [COORD_BITS-1:0]      cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg;
    logic [COORD_BITS-1:0]      cur_y_next;
    logic [COORD_BITS-1:0]      end_x_reg;
    logic [COORD_BITS-1:0]      end_y_reg;
    logic signed [DEC_BITS-1:0] decision_reg;
    logic signed [DEC_BITS-1:0] decision_next;
    logic signed [DEC_BITS-1:0] inc_minor_reg;
    logic signed [DEC_BITS-1:0] inc_both_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COORD_BITS-1:0]      pixel_x_reg;
    logic [COORD_BITS-1:0]      pixel_y_reg;
    logic                       last_reg;
    logic                       out_free;
    logic                       do_load;
    logic                       do_emit;
    logic                       is_last;
    logic                       minor_step;
    logic [COORD_BITS-1:0]      x_walk;
    logic [COORD_BITS-1:0]      y_walk;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        do_load   = entry_valid && entry_ctrl.load;
        do_emit   = entry_valid && !entry_ctrl.load && active_reg && out_free;
        // A step with no line loaded is dropped without waiting for output.
        entry_pop = do_load || do_emit || (entry_valid && !entry_ctrl.load && !active_reg);

        is_last    = ctrl_reg.steep ? (cur_y_reg == end_y_reg) : (cur_x_reg == end_x_reg);
        minor_step = !decision_reg[DEC_BITS-1];
        x_walk     = ctrl_reg.x_negative ? (cur_x_reg - COORD_BITS'(1))
                                         : (cur_x_reg + COORD_BITS'(1));
        y_walk     = ctrl_reg.y_negative ? (cur_y_reg - COORD_BITS'(1))
                                         : (cur_y_reg + COORD_BITS'(1));

        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        decision_next = decision_reg;
        active_next   = active_reg;

        if (do_emit)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (ctrl_reg.steep || minor_step)
                begin
                    cur_y_next = y_walk;
                end
                if (!ctrl_reg.steep || minor_step)
                begin
                    cur_x_next = x_walk;
                end
                decision_next = decision_reg + (minor_step ? inc_both_reg : inc_minor_reg);
            end
        end

        if (do_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid  = out_valid_reg;
        pixel_x    = pixel_x_reg;
        pixel_y    = pixel_y_reg;
        last_pixel = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            decision_reg  <= '0;
            inc_minor_reg <= '0;
            inc_both_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_load)
            begin
                ctrl_reg      <= entry_ctrl;
                active_reg    <= 1'b1;
                cur_x_reg     <= entry_start_x;
                cur_y_reg     <= entry_start_y;
                end_x_reg     <= entry_end_x;
                end_y_reg     <= entry_end_y;
                decision_reg  <= entry_decision;
                inc_minor_reg <= entry_inc_minor;
                inc_both_reg  <= entry_inc_both;
            end
            else
            begin
                active_reg   <= active_next;
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
                decision_reg <= decision_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            pixel_x_reg <= cur_x_reg;
            pixel_y_reg <= cur_y_reg;
            last_reg    <= is_last;
        end
    end

endmodule

>>> rtl/core/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Integer line generator that walks all eight octants one pixel at a time.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries commands. When s_axis_tuser is low the transaction
// loads a new line from (x_start, y_start) to (x_finish, y_finish) and gives
// no pixel; a load always restarts the walk, even in the middle of a line.
// When s_axis_tuser is high the transaction asks for the next pixel, which
// appears on the master stream with m_axis_tlast set on the finish point.
// A step with no line loaded, or after the finish point, gives nothing.
// An accepted step is written into the queue and its pixel is then held in
// the output register; the block takes one transaction every cycle while
// the queue has room. A two-entry queue sits between the command decoder
// and the pixel engine, which advances the line with one add and one compare
// per pixel. When the receiver holds m_axis_tready low the pixel stays in
// the output register, steps wait and s_axis_tready drops on a full queue.
// Reset empties the queue and the output register and leaves no line loaded.
// ----------------------------------------------------------------------------
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int unsigned COORD_BITS = 11
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0 up: x_start, y_start, x_finish, y_finish, zero padding.
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Field: opcode (low loads endpoints, high requests the next pixel).
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, zero padding.
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // Marks the finish point of the line.
    output logic                   m_axis_tlast
);

    localparam int unsigned DEC_BITS  = COORD_BITS + 3;
    localparam int unsigned OUT_W     = ((2*COORD_BITS+7)/8)*8;
    localparam int unsigned OUT_PAD   = OUT_W - 2*COORD_BITS;
    localparam int unsigned ENTRY_W   = CTRL_BITS + 4*COORD_BITS + 3*DEC_BITS;

    // Command fields unpacked from the slave transaction.
    logic [COORD_BITS-1:0]      x_start;
    logic [COORD_BITS-1:0]      y_start;
    logic [COORD_BITS-1:0]      x_finish;
    logic [COORD_BITS-1:0]      y_finish;

    // Front end results.
    bls_ctrl_t                  front_ctrl;
    logic signed [DEC_BITS-1:0] front_decision;
    logic signed [DEC_BITS-1:0] front_inc_minor;
    logic signed [DEC_BITS-1:0] front_inc_both;

    // Queue signals.
    logic [ENTRY_W-1:0]         queue_wr_data;
    logic [ENTRY_W-1:0]         queue_rd_data;
    logic                       queue_full;
    logic                       queue_empty;
    logic                       queue_pop;

    // Fields of the entry at the head of the queue.
    bls_ctrl_t                  head_ctrl;
    logic [COORD_BITS-1:0]      head_start_x;
    logic [COORD_BITS-1:0]      head_start_y;
    logic [COORD_BITS-1:0]      head_end_x;
    logic [COORD_BITS-1:0]      head_end_y;
    logic signed [DEC_BITS-1:0] head_decision;
    logic signed [DEC_BITS-1:0] head_inc_minor;
    logic signed [DEC_BITS-1:0] head_inc_both;

    // Back end outputs.
    logic [COORD_BITS-1:0]      pixel_x;
    logic [COORD_BITS-1:0]      pixel_y;

    assign x_start  = s_axis_tdata[COORD_BITS-1:0];
    assign y_start  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x_finish = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y_finish = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // The decoder is ready whenever the queue has room.
    assign s_axis_tready = !queue_full;

    bls_front #(
        .COORD_BITS (COORD_BITS),
        .DEC_BITS   (DEC_BITS)
    ) u_front (
        .opcode        (s_axis_tuser),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_finish      (x_finish),
        .y_finish      (y_finish),
        .ctrl          (front_ctrl),
        .decision_init (front_decision),
        .inc_minor     (front_inc_minor),
        .inc_both      (front_inc_both)
    );

    assign queue_wr_data = {front_ctrl, x_start, y_start, x_finish, y_finish,
                            front_decision, front_inc_minor, front_inc_both};

    bls_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_axis_tvalid),
        .wr_data  (queue_wr_data),
        .full     (queue_full),
        .rd_en    (queue_pop),
        .rd_data  (queue_rd_data),
        .empty    (queue_empty)
    );

    assign {head_ctrl, head_start_x, head_start_y, head_end_x, head_end_y,
            head_decision, head_inc_minor, head_inc_both} = queue_rd_data;

    bls_back #(
        .COORD_BITS (COORD_BITS),
        .DEC_BITS   (DEC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .entry_valid     (!queue_empty),
        .entry_ctrl      (head_ctrl),
        .entry_start_x   (head_start_x),
        .entry_start_y   (head_start_y),
        .entry_end_x     (head_end_x),
        .entry_end_y     (head_end_y),
        .entry_decision  (head_decision),
        .entry_inc_minor (head_inc_minor),
        .entry_inc_both  (head_inc_both),
        .entry_pop       (queue_pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .last_pixel      (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, pixel_y, pixel_x};

endmodule
